@@ src/r2y_pkg.sv @@
// Shared types and constants of the RGB to YUV 4:2:0 converter.
package r2y_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned SIZE_W     = 14;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;

  // Queue depths and occupancy count widths
  localparam int unsigned MID_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned MID_CNT_W   = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  // BT.601 weights, scaled by 1000
  localparam int unsigned Y_KR   = 257;
  localparam int unsigned Y_KG   = 504;
  localparam int unsigned Y_KB   = 98;
  localparam int unsigned Y_OFS  = 16;
  localparam int unsigned CB_KR  = 148;
  localparam int unsigned CB_KG  = 291;
  localparam int unsigned CB_KB  = 439;
  localparam int unsigned CR_KR  = 439;
  localparam int unsigned CR_KG  = 368;
  localparam int unsigned CR_KB  = 71;
  localparam int unsigned C_OFS  = 128000;

  // Weighted sums stay below 2^18
  localparam int unsigned SUM_W  = 18;

  // floor(x / 1000) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2^18
  localparam int unsigned RECIP_M     = 268436;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        chroma;
    logic [8:0]  sum_r;
    logic [8:0]  sum_g;
    logic [8:0]  sum_b;
    logic [26:0] pair;
    logic        frame_end;
  } mid_item_t;

  // Finished result beat
  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       frame_end;
  } res_item_t;

endpackage

@@ src/r2y_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module r2y_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/r2y_fifo.sv @@
// Small register queue with occupancy count.
module r2y_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < CW'(DEPTH)) || rd_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> count_r != '0)
    else $error("queue read while empty");
`endif

endmodule

@@ src/r2y_front.sv @@
// Front part: raster counters, pair sums, line store and pixel classification.
module r2y_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [r2y_pkg::CFG_W-1:0]      frame_width,
  input  logic [r2y_pkg::CFG_W-1:0]      frame_height,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [r2y_pkg::MID_CNT_W-1:0]  q_count,
  output logic                           item_valid,
  output r2y_pkg::mid_item_t             item
);

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned SW         = r2y_pkg::SIZE_W;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [23:0]        held_r, held_nxt;
  logic               stg_v_r;
  r2y_pkg::mid_item_t stg_r, stg_nxt;
  logic [SW-1:0]      w_eff, h_eff;
  logic               accept;
  logic               line_end, frame_last;
  logic [8:0]         sum_r, sum_g, sum_b;
  logic [SLOT_W-1:0]  slot;
  logic               ram_wr, ram_rd;
  logic [26:0]        pair_rdata;
  logic [r2y_pkg::MID_CNT_W:0] q_used;

  // Hold off while the queue could not take what is in flight
  assign q_used = {1'b0, q_count} + (r2y_pkg::MID_CNT_W + 1)'(stg_v_r);
  assign full   = q_used >= (r2y_pkg::MID_CNT_W + 1)'(r2y_pkg::MID_DEPTH);
  assign accept = push && !full;

  // Clamp frame size to the supported range
  always_comb begin
    if (frame_width < r2y_pkg::CFG_W'(2)) begin
      w_eff = SW'(2);
    end else if (SW'(frame_width) > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(frame_width);
    end
    if (frame_height < r2y_pkg::CFG_W'(2)) begin
      h_eff = SW'(2);
    end else if (SW'(frame_height) > SW'(MAX_HEIGHT)) begin
      h_eff = SW'(MAX_HEIGHT);
    end else begin
      h_eff = SW'(frame_height);
    end
  end

  assign line_end   = (SW'(col_r) + SW'(1)) >= w_eff;
  assign frame_last = (SW'(row_r) + SW'(1)) >= h_eff;

  // Horizontal pair sums against the held even-column pixel
  assign sum_r = {1'b0, red}   + {1'b0, held_r[7:0]};
  assign sum_g = {1'b0, green} + {1'b0, held_r[15:8]};
  assign sum_b = {1'b0, blue}  + {1'b0, held_r[23:16]};
  assign slot  = SLOT_W'(col_r >> 1);

  assign ram_wr = accept && col_r[0] && !row_r[0];
  assign ram_rd = accept && col_r[0] && row_r[0];

  // Advance counters and held pixel
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (accept) begin
      if (!col_r[0]) begin
        held_nxt = {blue, green, red};
      end
      if (line_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // Classify the beat for the back part
  always_comb begin
    stg_nxt           = stg_r;
    stg_nxt.red       = red;
    stg_nxt.green     = green;
    stg_nxt.blue      = blue;
    stg_nxt.chroma    = col_r[0] && row_r[0];
    stg_nxt.sum_r     = sum_r;
    stg_nxt.sum_g     = sum_g;
    stg_nxt.sum_b     = sum_b;
    stg_nxt.pair      = '0;
    stg_nxt.frame_end = line_end && frame_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      held_r  <= '0;
      stg_v_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      held_r  <= held_nxt;
      stg_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

  // Line store of even-row pair sums
  r2y_ram #(
    .WIDTH (27),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (slot),
    .wr_data ({sum_b, sum_g, sum_r}),
    .rd_en   (ram_rd),
    .rd_addr (slot),
    .rd_data (pair_rdata)
  );

  // Join the stage with the line store read
  always_comb begin
    item      = stg_r;
    item.pair = pair_rdata;
  end

  assign item_valid = stg_v_r;

`ifndef SYNTHESIS
  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> item_valid)
    else $error("accepted pixel did not reach the front stage");
`endif

endmodule

@@ src/r2y_back.sv @@
// Back part: luma and chroma arithmetic with reciprocal division by 1000.
module r2y_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           avail,
  input  r2y_pkg::mid_item_t             item,
  output logic                           take,
  input  logic [r2y_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                           res_valid,
  output r2y_pkg::res_item_t             res
);

  localparam int unsigned SW = r2y_pkg::SUM_W;
  localparam int unsigned PW = r2y_pkg::PROD_W;
  localparam int unsigned CW = r2y_pkg::OUT_CNT_W + 2;

  // Stage 1: luma sum and block averages
  logic          b1_v_r, b1_chroma_r, b1_fend_r;
  logic [SW-1:0] b1_ysum_r;
  logic [7:0]    b1_ar_r, b1_ag_r, b1_ab_r;
  // Stage 2: chroma numerators
  logic          b2_v_r, b2_chroma_r, b2_fend_r;
  logic [SW-1:0] b2_ysum_r, b2_cb_r, b2_cr_r;
  // Stage 3: reciprocal products
  logic          b3_v_r, b3_chroma_r, b3_fend_r;
  logic [PW-1:0] b3_yp_r, b3_cbp_r, b3_crp_r;

  logic [SW-1:0] ysum_nxt, cb_nxt, cr_nxt;
  logic [7:0]    ar_nxt, ag_nxt, ab_nxt;
  logic [CW-1:0] used;
  logic [7:0]    yq, cbq, crq;

  // Take a beat only when the output queue has room for all in flight
  assign used = CW'(out_count) + CW'(b1_v_r) + CW'(b2_v_r) + CW'(b3_v_r);
  assign take = avail && (used < CW'(r2y_pkg::OUT_DEPTH));

  always_comb begin
    ysum_nxt = SW'(SW'(item.red)   * SW'(r2y_pkg::Y_KR))
             + SW'(SW'(item.green) * SW'(r2y_pkg::Y_KG))
             + SW'(SW'(item.blue)  * SW'(r2y_pkg::Y_KB));
    ar_nxt = 8'((10'(item.sum_r) + 10'(item.pair[8:0]))   >> 2);
    ag_nxt = 8'((10'(item.sum_g) + 10'(item.pair[17:9]))  >> 2);
    ab_nxt = 8'((10'(item.sum_b) + 10'(item.pair[26:18])) >> 2);
  end

  // Numerators stay non-negative, so modular arithmetic is exact
  always_comb begin
    cb_nxt = SW'(SW'(b1_ab_r) * SW'(r2y_pkg::CB_KB)) + SW'(r2y_pkg::C_OFS)
           - SW'(SW'(b1_ar_r) * SW'(r2y_pkg::CB_KR))
           - SW'(SW'(b1_ag_r) * SW'(r2y_pkg::CB_KG));
    cr_nxt = SW'(SW'(b1_ar_r) * SW'(r2y_pkg::CR_KR)) + SW'(r2y_pkg::C_OFS)
           - SW'(SW'(b1_ag_r) * SW'(r2y_pkg::CR_KG))
           - SW'(SW'(b1_ab_r) * SW'(r2y_pkg::CR_KB));
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= take;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    b1_chroma_r <= item.chroma;
    b1_fend_r   <= item.frame_end;
    b1_ysum_r   <= ysum_nxt;
    b1_ar_r     <= ar_nxt;
    b1_ag_r     <= ag_nxt;
    b1_ab_r     <= ab_nxt;

    b2_chroma_r <= b1_chroma_r;
    b2_fend_r   <= b1_fend_r;
    b2_ysum_r   <= b1_ysum_r;
    b2_cb_r     <= cb_nxt;
    b2_cr_r     <= cr_nxt;

    b3_chroma_r <= b2_chroma_r;
    b3_fend_r   <= b2_fend_r;
    b3_yp_r     <= PW'(b2_ysum_r) * PW'(r2y_pkg::RECIP_M);
    b3_cbp_r    <= PW'(b2_cb_r)   * PW'(r2y_pkg::RECIP_M);
    b3_crp_r    <= PW'(b2_cr_r)   * PW'(r2y_pkg::RECIP_M);
  end

  // Drop the fraction, add the luma offset, zero chroma off-block
  assign yq  = b3_yp_r[r2y_pkg::RECIP_SHIFT +: 8];
  assign cbq = b3_cbp_r[r2y_pkg::RECIP_SHIFT +: 8];
  assign crq = b3_crp_r[r2y_pkg::RECIP_SHIFT +: 8];

  always_comb begin
    res.luma         = yq + 8'(r2y_pkg::Y_OFS);
    res.chroma_valid = b3_chroma_r;
    res.chroma_blue  = b3_chroma_r ? cbq : 8'd0;
    res.chroma_red   = b3_chroma_r ? crq : 8'd0;
    res.frame_end    = b3_fend_r;
  end

  assign res_valid = b3_v_r;

endmodule

@@ src/rgb_to_yuv420_converter.sv @@
// Top level of the BT.601 RGB to YUV 4:2:0 converter.
//
// Pixels enter in raster order on the input queue port: a beat is taken at a
// clock edge with in_push high and in_full low. Each pixel gives one result
// beat with its luma; the pixel at an odd row and odd column also carries the
// chroma of its 2x2 block (chroma_valid high), and the last pixel of a frame
// carries frame_end. Results are read like a queue: the oldest result sits on
// the out_ ports while out_empty is low and leaves at an edge with out_pop high.
// One pixel is taken per clock while in_full stays low; a taken pixel
// passes the front stage with its line-store read, the middle queue, the back
// part's three arithmetic stages and the result queue write. A four-entry queue
// parts front and back and an eight-entry result queue absorbs receiver stalls;
// when it fills, the back part stops taking beats and in_full rises once the
// middle queue fills. cfg_wr_en writes frame_width (index 0) or frame_height
// (index 1); the user must write them only while the block is idle, which the
// block does not enforce. Sizes below 2 act as 2 and sizes above the maximum as
// the maximum. Reset empties both queues, sets the counters to the frame start
// and the sizes to 1920 by 1080; the line store needs no clearing.
module rgb_to_yuv420_converter #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_luma,
  output logic                      out_chroma_valid,
  output logic [7:0]                out_chroma_blue,
  output logic [7:0]                out_chroma_red,
  output logic                      out_frame_end
);

  logic [r2y_pkg::CFG_W-1:0]     width_r, width_nxt;
  logic [r2y_pkg::CFG_W-1:0]     height_r, height_nxt;
  logic [r2y_pkg::MID_CNT_W-1:0] mid_count;
  logic [r2y_pkg::OUT_CNT_W-1:0] out_count;
  logic                          mid_wr, mid_rd, res_valid, out_rd;
  r2y_pkg::mid_item_t            mid_wr_item, mid_rd_item;
  r2y_pkg::res_item_t            res_item, out_item;

  // Configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      case (r2y_pkg::cfg_reg_t'(cfg_index))
        r2y_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        r2y_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: begin
          width_nxt  = width_r;
          height_nxt = height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= r2y_pkg::WIDTH_RESET;
      height_r <= r2y_pkg::HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  r2y_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (width_r),
    .frame_height (height_r),
    .push         (in_push),
    .full         (in_full),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .q_count      (mid_count),
    .item_valid   (mid_wr),
    .item         (mid_wr_item)
  );

  r2y_fifo #(
    .WIDTH ($bits(r2y_pkg::mid_item_t)),
    .DEPTH (r2y_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wr_item),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_item),
    .count   (mid_count)
  );

  r2y_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (mid_count != '0),
    .item      (mid_rd_item),
    .take      (mid_rd),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res_item)
  );

  r2y_fifo #(
    .WIDTH ($bits(r2y_pkg::res_item_t)),
    .DEPTH (r2y_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res_item),
    .rd_en   (out_rd),
    .rd_data (out_item),
    .count   (out_count)
  );

  // Present the oldest result beat
  assign out_empty        = out_count == '0;
  assign out_rd           = out_pop && !out_empty;
  assign out_luma         = out_item.luma;
  assign out_chroma_valid = out_item.chroma_valid;
  assign out_chroma_blue  = out_item.chroma_blue;
  assign out_chroma_red   = out_item.chroma_red;
  assign out_frame_end    = out_item.frame_end;

`ifndef SYNTHESIS
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_chroma_valid) |-> out_chroma_blue == 8'd0 && out_chroma_red == 8'd0)
    else $error("chroma shown without a completed block");
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_luma >= 8'd16 && out_luma <= 8'd235)
    else $error("luma outside studio range");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the RGB to YUV 4:2:0 converter, with its own pixel predictor.
module tb_top;
  import r2y_pkg::*;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned RANDOM_PIXELS = 520;
  localparam int unsigned DRAIN_CYCLES  = 10;

  // One directed step: optional size change, then a pixel and, where fixed, its result
  typedef struct packed {
    logic             set_sizes;
    logic [CFG_W-1:0] new_width;
    logic [CFG_W-1:0] new_height;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             fixed;
    res_item_t        want;
  } pixel_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [0:0]       cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_push   = 1'b0;
  logic             in_full;
  logic [7:0]       in_red    = '0;
  logic [7:0]       in_green  = '0;
  logic [7:0]       in_blue   = '0;
  logic             out_empty;
  logic             out_pop   = 1'b0;
  logic [7:0]       out_luma;
  logic             out_chroma_valid;
  logic [7:0]       out_chroma_blue;
  logic [7:0]       out_chroma_red;
  logic             out_frame_end;

  // Side data that travels with the pixel beat
  logic             row_fixed = 1'b0;
  res_item_t        row_want  = '0;

  bit               send_gaps  = 1'b1;
  bit               pop_stalls = 1'b1;
  int unsigned      mismatches = 0;

  // Predictor state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [11:0]      col_pos;
  logic [11:0]      row_pos;
  logic [23:0]      held_pixel;
  logic [26:0]      pair_sums [MAX_W/2];
  res_item_t        yuv_expected [$];

  // Directed steps: black and white at reset size, a mid-line shrink to 2x2 through
  // sizes under two, saturated red and blue blocks, then an odd 3x3 frame
  pixel_row_t directed_rows [22] = '{
    '{0, 0, 0,   0,   0,   0, 1, '{ 16, 0,   0,   0, 0}},
    '{0, 0, 0, 255, 255, 255, 1, '{235, 0,   0,   0, 0}},
    '{1, 0, 1,   0,   0,   0, 1, '{ 16, 0,   0,   0, 0}},
    '{0, 0, 0, 255, 255, 255, 1, '{235, 0,   0,   0, 0}},
    '{0, 0, 0, 255, 255, 255, 1, '{235, 1, 128, 128, 1}},
    '{1, 2, 2, 255,   0,   0, 1, '{ 81, 0,   0,   0, 0}},
    '{0, 0, 0, 255,   0,   0, 1, '{ 81, 0,   0,   0, 0}},
    '{0, 0, 0, 255,   0,   0, 1, '{ 81, 0,   0,   0, 0}},
    '{0, 0, 0, 255,   0,   0, 1, '{ 81, 1,  90, 239, 1}},
    '{0, 0, 0,   0,   0, 255, 1, '{ 40, 0,   0,   0, 0}},
    '{0, 0, 0,   0,   0, 255, 1, '{ 40, 0,   0,   0, 0}},
    '{0, 0, 0,   0,   0, 255, 1, '{ 40, 0,   0,   0, 0}},
    '{0, 0, 0,   0,   0, 255, 1, '{ 40, 1, 239, 109, 1}},
    '{1, 3, 3,   0, 255,   0, 0, '0},
    '{0, 0, 0,  17,  34,  51, 0, '0},
    '{0, 0, 0, 100, 200,  50, 0, '0},
    '{0, 0, 0, 255,   0, 255, 0, '0},
    '{0, 0, 0,   1, 128, 254, 0, '0},
    '{0, 0, 0,  77,  77,  77, 0, '0},
    '{0, 0, 0, 200,  10,  90, 0, '0},
    '{0, 0, 0,   0,   0, 255, 0, '0},
    '{0, 0, 0, 254,   1, 127, 0, '0}
  };

  rgb_to_yuv420_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_frame_end    (out_frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Size as the block uses it: pinned between 2 and the maximum
  function automatic int unsigned effective_size(input logic [CFG_W-1:0] size,
                                                 input int unsigned ceiling);
    if (size < 2) return 2;
    if (size > ceiling) return ceiling;
    return size;
  endfunction

  // Convert one pixel and advance the raster position
  function automatic res_item_t convert_pixel(input logic [7:0] r, g, b);
    int unsigned w_eff, h_eff, sr, sg, sb, ar, ag, ab;
    logic [10:0] slot;
    res_item_t   beat;
    w_eff = effective_size(width_reg, MAX_W);
    h_eff = effective_size(height_reg, MAX_H);
    slot  = col_pos[11:1];
    beat  = '0;
    // BT.601 weights scaled by 1000
    beat.luma = 8'((257 * r + 504 * g + 98 * b) / 1000 + 16);
    if (!col_pos[0]) begin
      held_pixel = {b, g, r};
    end else begin
      sr = r + held_pixel[7:0];
      sg = g + held_pixel[15:8];
      sb = b + held_pixel[23:16];
      if (!row_pos[0]) begin
        pair_sums[slot] = {9'(sb), 9'(sg), 9'(sr)};
      end else begin
        ar = (sr + pair_sums[slot][8:0]) >> 2;
        ag = (sg + pair_sums[slot][17:9]) >> 2;
        ab = (sb + pair_sums[slot][26:18]) >> 2;
        beat.chroma_blue  = 8'((439 * ab + 128000 - 148 * ar - 291 * ag) / 1000);
        beat.chroma_red   = 8'((439 * ar + 128000 - 368 * ag - 71 * ab) / 1000);
        beat.chroma_valid = 1'b1;
      end
    end
    if (int'(col_pos) + 1 >= w_eff) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= h_eff) begin
        row_pos = '0;
        beat.frame_end = 1'b1;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return beat;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(input string field, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Offer one pixel beat, with an optional gap ahead of it, and hold it until taken
  task automatic send_pixel(input logic [7:0] r, g, b, input logic fixed,
                            input res_item_t want);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_red    <= r;
    in_green  <= g;
    in_blue   <= b;
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_level(), random_level(), random_level(), 1'b0, '0);
  endtask

  // Drop push and hold until every predicted beat has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (yuv_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] w, h);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Track register writes, predict accepted pixels, compare popped beats
  always @(posedge clk) begin : yuv_scoreboard
    res_item_t beat;
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos    = '0;
      row_pos    = '0;
      held_pixel = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_wdata;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        beat = convert_pixel(in_red, in_green, in_blue);
        yuv_expected.insert(yuv_expected.size(), row_fixed ? row_want : beat);
      end
      if (out_pop && !out_empty) begin
        if (yuv_expected.size() == 0) begin
          $display("%0t: beat with no pixel pending, expected none actual luma %0d",
                   $time, out_luma);
          mismatches++;
        end else begin
          beat = yuv_expected.pop_front();
          check_field("luma", beat.luma, out_luma);
          check_field("chroma_valid", beat.chroma_valid, out_chroma_valid);
          check_field("chroma_blue", beat.chroma_blue, out_chroma_blue);
          check_field("chroma_red", beat.chroma_red, out_chroma_red);
          check_field("frame_end", beat.frame_end, out_frame_end);
        end
      end
    end
  end

  // Result side: pop, with random stall bursts while enabled
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (pop_stalls && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #(20 * 1000000);
    $display("tb_top: errors");
    $finish;
  end

  // Pixel side: directed steps, random frames, the size extremes, back-to-back frames, then drain
  initial begin : stimulus
    int unsigned      random_count;
    int unsigned      pixels;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_sizes)
        write_sizes(directed_rows[i].new_width, directed_rows[i].new_height);
      send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                 directed_rows[i].fixed, directed_rows[i].want);
    end

    // Whole frames of random pixels at random small sizes, odd ones included
    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      case ($urandom_range(0, 5))
        0: w = $urandom_range(0, 1);
        1: w = 2;
        default: w = $urandom_range(3, 24);
      endcase
      case ($urandom_range(0, 4))
        0: h = $urandom_range(0, 1);
        default: h = $urandom_range(2, 9);
      endcase
      write_sizes(w, h);
      send_gaps  = ($urandom_range(0, 3) != 0);
      pop_stalls = ($urandom_range(0, 3) != 0);
      pixels = effective_size(w, MAX_W) * effective_size(h, MAX_H) * $urandom_range(1, 3);
      send_random(pixels);
      random_count += pixels;
    end

    // Widest size, then shrink in the first line so its next pixel ends the line
    send_gaps  = 1'b1;
    pop_stalls = 1'b1;
    write_sizes('1, '0);
    send_random(6);
    write_sizes(2, 0);
    send_random(3);

    // Tallest size, then shrink a few lines down so the next line end ends the frame
    write_sizes(0, '1);
    send_random(8);
    write_sizes(0, 0);
    send_random(2);

    // Back-to-back frames, no idling on either side
    write_sizes(16, 4);
    send_gaps  = 1'b0;
    pop_stalls = 1'b0;
    send_random(128);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && yuv_expected.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
